### src/btrs_pkg.sv
// ----------------------------------------------------------------------------
// btrs_pkg
// Shared types and constants of the block transfer receiver session unit.
// ----------------------------------------------------------------------------
package btrs_pkg;

  localparam logic [15:0] MaxBlockBytes = 16'd1024;

  localparam logic [7:0] MaxTimeoutsReset  = 8'd5;
  localparam logic [7:0] MaxBadPktsReset   = 8'd20;
  localparam logic [7:0] MaxForeignReset   = 8'd5;

  typedef enum logic [1:0] {
    CFG_MAX_TIMEOUTS = 2'd0,
    CFG_MAX_BAD      = 2'd1,
    CFG_MAX_FOREIGN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_PACKET   = 2'd1,
    MODE_TIMEOUT  = 2'd2,
    MODE_RECV_ERR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STORE_OK        = 2'd0,
    STORE_WRITE_ERR = 2'd1
  } store_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_READ_REQ = 3'd1,
    ACT_ACK      = 3'd2,
    ACT_FINISHED = 3'd3,
    ACT_ABORT    = 3'd4,
    ACT_FAILED   = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ACK_READ_NEXT = 2'd0,
    ACK_WRITE_ERR = 2'd1,
    ACK_UNDEFINED = 2'd2
  } ack_code_t;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_OPEN_FAILED   = 3'd1,
    ERR_REMOTE_NACK   = 3'd2,
    ERR_FOREIGN       = 3'd3,
    ERR_BAD_PACKETS   = 3'd4,
    ERR_TIMEOUT_LIMIT = 3'd5
  } err_code_t;

endpackage

### src/block_transfer_receiver_session_unit.sv
// ----------------------------------------------------------------------------
// block_transfer_receiver_session_unit
// Receiver session control of a stop-and-wait block file transfer.
// ----------------------------------------------------------------------------
// Path: an accepted transfer waits in the input register and moves to the
//   result register once that register is empty or its result is taken.
// Throughput: one transfer per cycle while no result is stalled; state is
//   updated as each item leaves the input register, so the next item sees it.
// Reset: synchronous, active low; clears session state, counters, valid flags
//   and sets the limit registers to 5, 20 and 5.
module block_transfer_receiver_session_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic        in_user_abort,
  input  logic [1:0]  in_store_result,
  input  logic        in_is_data_command,
  input  logic        in_packet_check_ok,
  input  logic [15:0] in_packet_session,
  input  logic        in_packet_is_nack,
  input  logic [31:0] in_packet_block,
  input  logic [31:0] in_packet_total_size,
  input  logic [10:0] in_packet_data_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [1:0]  out_ack_code,
  output logic [15:0] out_ack_session,
  output logic [31:0] out_ack_block,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_remote_error
);

  logic [7:0] max_timeouts_r, max_bad_r, max_foreign_r;

  logic        s1_valid_r;
  logic [1:0]  mode_r;
  logic        abort_r;
  logic [1:0]  store_r;
  logic        is_data_r;
  logic        check_ok_r;
  logic [15:0] psess_r;
  logic        is_nack_r;
  logic [31:0] pblock_r;
  logic [31:0] ptotal_r;
  logic [10:0] plen_r;

  logic               active_r, active_nxt;
  logic [15:0]        session_id_r, session_id_nxt;
  logic [31:0]        last_block_r, last_block_nxt;
  logic signed [32:0] bytes_left_r, bytes_left_nxt;
  logic [7:0]         timeout_cnt_r, timeout_cnt_nxt;
  logic [7:0]         bad_cnt_r, bad_cnt_nxt;
  logic [7:0]         foreign_cnt_r, foreign_cnt_nxt;

  btrs_pkg::action_t   act;
  btrs_pkg::ack_code_t ack;
  btrs_pkg::err_code_t err;
  logic [31:0]         remote;

  logic               advance, fire;
  logic signed [32:0] bytes_base, bytes_sub;
  logic               oversize;

  logic        out_valid_r;
  logic [2:0]  action_r;
  logic [1:0]  ack_code_r;
  logic [15:0] ack_session_r;
  logic [31:0] ack_block_r;
  logic [2:0]  error_code_r;
  logic [31:0] remote_error_r;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_timeouts_r <= btrs_pkg::MaxTimeoutsReset;
      max_bad_r      <= btrs_pkg::MaxBadPktsReset;
      max_foreign_r  <= btrs_pkg::MaxForeignReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btrs_pkg::CFG_MAX_TIMEOUTS: max_timeouts_r <= cfg_data;
        btrs_pkg::CFG_MAX_BAD:      max_bad_r      <= cfg_data;
        btrs_pkg::CFG_MAX_FOREIGN:  max_foreign_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_r     <= in_mode;
      abort_r    <= in_user_abort;
      store_r    <= in_store_result;
      is_data_r  <= in_is_data_command;
      check_ok_r <= in_packet_check_ok;
      psess_r    <= in_packet_session;
      is_nack_r  <= in_packet_is_nack;
      pblock_r   <= in_packet_block;
      ptotal_r   <= in_packet_total_size;
      plen_r     <= in_packet_data_length;
    end
  end

  assign oversize   = {5'd0, plen_r} > btrs_pkg::MaxBlockBytes;
  assign bytes_base = (pblock_r == 32'd1) ? $signed({1'b0, ptotal_r}) : bytes_left_r;
  assign bytes_sub  = bytes_base - $signed({22'd0, plen_r});

  // session logic
  always_comb begin
    active_nxt      = active_r;
    session_id_nxt  = session_id_r;
    last_block_nxt  = last_block_r;
    bytes_left_nxt  = bytes_left_r;
    timeout_cnt_nxt = timeout_cnt_r;
    bad_cnt_nxt     = bad_cnt_r;
    foreign_cnt_nxt = foreign_cnt_r;
    act    = btrs_pkg::ACT_NONE;
    ack    = btrs_pkg::ACK_READ_NEXT;
    err    = btrs_pkg::ERR_NONE;
    remote = 32'd0;

    if (mode_r == btrs_pkg::MODE_START) begin
      active_nxt = 1'b0;
      if (store_r != btrs_pkg::STORE_OK) begin
        act = btrs_pkg::ACT_FAILED;
        err = btrs_pkg::ERR_OPEN_FAILED;
      end else begin
        session_id_nxt  = session_id_r + 16'd1;
        timeout_cnt_nxt = 8'd0;
        bad_cnt_nxt     = 8'd0;
        foreign_cnt_nxt = 8'd0;
        last_block_nxt  = 32'd0;
        bytes_left_nxt  = 33'sd0;
        active_nxt      = 1'b1;
        act             = btrs_pkg::ACT_READ_REQ;
      end
    end else if (!active_r) begin
      act = btrs_pkg::ACT_NONE;
    end else if (abort_r) begin
      active_nxt = 1'b0;
      act        = btrs_pkg::ACT_ABORT;
    end else if (mode_r == btrs_pkg::MODE_TIMEOUT) begin
      if (timeout_cnt_r >= max_timeouts_r) begin
        active_nxt = 1'b0;
        act        = btrs_pkg::ACT_FAILED;
        err        = btrs_pkg::ERR_TIMEOUT_LIMIT;
      end else begin
        timeout_cnt_nxt = timeout_cnt_r + 8'd1;
        act             = btrs_pkg::ACT_ACK;
      end
    end else if (mode_r == btrs_pkg::MODE_PACKET) begin
      timeout_cnt_nxt = 8'd0;
      if (!is_data_r) begin
        act = btrs_pkg::ACT_NONE;
      end else if (!check_ok_r || oversize) begin
        if (bad_cnt_r >= max_bad_r) begin
          active_nxt = 1'b0;
          act        = btrs_pkg::ACT_FAILED;
          err        = btrs_pkg::ERR_BAD_PACKETS;
        end else begin
          bad_cnt_nxt = bad_cnt_r + 8'd1;
          act         = btrs_pkg::ACT_ACK;
        end
      end else begin
        bad_cnt_nxt = 8'd0;
        if (psess_r != session_id_r) begin
          if (foreign_cnt_r >= max_foreign_r) begin
            active_nxt = 1'b0;
            act        = btrs_pkg::ACT_FAILED;
            err        = btrs_pkg::ERR_FOREIGN;
          end else begin
            foreign_cnt_nxt = foreign_cnt_r + 8'd1;
          end
        end else if (is_nack_r) begin
          active_nxt = 1'b0;
          act        = btrs_pkg::ACT_FAILED;
          err        = btrs_pkg::ERR_REMOTE_NACK;
          remote     = ptotal_r;
        end else if (pblock_r == last_block_r) begin
          act = btrs_pkg::ACT_ACK;
        end else if (pblock_r == last_block_r + 32'd1) begin
          last_block_nxt = pblock_r;
          bytes_left_nxt = bytes_base;
          if (store_r == btrs_pkg::STORE_OK) begin
            bytes_left_nxt = bytes_sub;
            if (bytes_sub[32] || bytes_sub == 33'sd0) begin
              active_nxt = 1'b0;
              act        = btrs_pkg::ACT_FINISHED;
            end else begin
              act = btrs_pkg::ACT_ACK;
            end
          end else begin
            act = btrs_pkg::ACT_ACK;
            ack = (store_r == btrs_pkg::STORE_WRITE_ERR) ? btrs_pkg::ACK_WRITE_ERR
                                                         : btrs_pkg::ACK_UNDEFINED;
          end
        end
      end
    end
  end

  // session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      session_id_r  <= 16'd0;
      last_block_r  <= 32'd0;
      bytes_left_r  <= 33'sd0;
      timeout_cnt_r <= 8'd0;
      bad_cnt_r     <= 8'd0;
      foreign_cnt_r <= 8'd0;
    end else if (fire) begin
      active_r      <= active_nxt;
      session_id_r  <= session_id_nxt;
      last_block_r  <= last_block_nxt;
      bytes_left_r  <= bytes_left_nxt;
      timeout_cnt_r <= timeout_cnt_nxt;
      bad_cnt_r     <= bad_cnt_nxt;
      foreign_cnt_r <= foreign_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      action_r       <= act;
      ack_code_r     <= ack;
      ack_session_r  <= session_id_nxt;
      ack_block_r    <= last_block_nxt;
      error_code_r   <= err;
      remote_error_r <= remote;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = action_r;
  assign out_ack_code     = ack_code_r;
  assign out_ack_session  = ack_session_r;
  assign out_ack_block    = ack_block_r;
  assign out_error_code   = error_code_r;
  assign out_remote_error = remote_error_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register can drain");

  a_fail_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_action == btrs_pkg::ACT_FAILED) == (out_error_code != btrs_pkg::ERR_NONE)))
    else $error("failure action and error code disagree");

  a_ack_code_only_on_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ack_code != btrs_pkg::ACK_READ_NEXT) |->
      (out_action == btrs_pkg::ACT_ACK))
    else $error("ack code set without ack action");

  a_remote_only_on_nack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_remote_error != 32'd0) |->
      (out_error_code == btrs_pkg::ERR_REMOTE_NACK))
    else $error("remote error without remote nack");

  a_start_request_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && act == btrs_pkg::ACT_READ_REQ) |=> (active_r && last_block_r == 32'd0))
    else $error("read request without fresh active session");

endmodule

### sim/btrs_session_checker.sv
// ----------------------------------------------------------------------------
// btrs_session_checker
// Watches the transfer and result channels of the receiver session unit,
// predicts one reply per accepted transfer from its own copy of the session
// state and limit registers, and compares each reply field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btrs_session_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic        in_user_abort,
  input  logic [1:0]  in_store_result,
  input  logic        in_is_data_command,
  input  logic        in_packet_check_ok,
  input  logic [15:0] in_packet_session,
  input  logic        in_packet_is_nack,
  input  logic [31:0] in_packet_block,
  input  logic [31:0] in_packet_total_size,
  input  logic [10:0] in_packet_data_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_action,
  input  logic [1:0]  out_ack_code,
  input  logic [15:0] out_ack_session,
  input  logic [31:0] out_ack_block,
  input  logic [2:0]  out_error_code,
  input  logic [31:0] out_remote_error,
  output int          pending,
  output int          mismatches,
  output int          checked
);

  typedef struct {
    btrs_pkg::action_t   action;
    btrs_pkg::ack_code_t ack;
    logic [15:0]         sess;
    logic [31:0]         blk;
    btrs_pkg::err_code_t err;
    logic [31:0]         remote;
  } session_reply_t;

  session_reply_t reply_q[$];

  logic [7:0]  lim_timeouts = btrs_pkg::MaxTimeoutsReset;
  logic [7:0]  lim_bad      = btrs_pkg::MaxBadPktsReset;
  logic [7:0]  lim_foreign  = btrs_pkg::MaxForeignReset;
  logic [15:0] cur_session  = '0;
  logic [31:0] cur_block    = '0;
  longint      remaining    = 0;
  logic [7:0]  timeout_cnt  = '0;
  logic [7:0]  bad_cnt      = '0;
  logic [7:0]  foreign_cnt  = '0;
  bit          active       = 1'b0;
  int          err_total    = 0;
  int          n_checked    = 0;

  function automatic session_reply_t session_step(
    input btrs_pkg::mode_t mode,
    input logic            abort_req,
    input logic [1:0]      store,
    input logic            is_data,
    input logic            chk_ok,
    input logic [15:0]     psess,
    input logic            nack,
    input logic [31:0]     pblock,
    input logic [31:0]     ptotal,
    input logic [10:0]     plen
  );
    session_reply_t r;
    r.action = btrs_pkg::ACT_NONE;
    r.ack    = btrs_pkg::ACK_READ_NEXT;
    r.err    = btrs_pkg::ERR_NONE;
    r.remote = '0;
    if (mode == btrs_pkg::MODE_START) begin
      active = 1'b0;
      if (store != btrs_pkg::STORE_OK) begin
        r.action = btrs_pkg::ACT_FAILED;
        r.err    = btrs_pkg::ERR_OPEN_FAILED;
      end else begin
        cur_session = cur_session + 16'd1;
        timeout_cnt = '0;
        bad_cnt     = '0;
        foreign_cnt = '0;
        cur_block   = '0;
        remaining   = 0;
        active      = 1'b1;
        r.action    = btrs_pkg::ACT_READ_REQ;
      end
    end else if (!active) begin
      r.action = btrs_pkg::ACT_NONE;
    end else if (abort_req) begin
      active   = 1'b0;
      r.action = btrs_pkg::ACT_ABORT;
    end else if (mode == btrs_pkg::MODE_TIMEOUT) begin
      if (timeout_cnt >= lim_timeouts) begin
        active   = 1'b0;
        r.action = btrs_pkg::ACT_FAILED;
        r.err    = btrs_pkg::ERR_TIMEOUT_LIMIT;
      end else begin
        timeout_cnt = timeout_cnt + 8'd1;
        r.action    = btrs_pkg::ACT_ACK;
      end
    end else if (mode == btrs_pkg::MODE_PACKET) begin
      timeout_cnt = '0;
      if (is_data) begin
        if (!chk_ok || plen > btrs_pkg::MaxBlockBytes) begin
          if (bad_cnt >= lim_bad) begin
            active   = 1'b0;
            r.action = btrs_pkg::ACT_FAILED;
            r.err    = btrs_pkg::ERR_BAD_PACKETS;
          end else begin
            bad_cnt  = bad_cnt + 8'd1;
            r.action = btrs_pkg::ACT_ACK;
          end
        end else begin
          bad_cnt = '0;
          if (psess != cur_session) begin
            if (foreign_cnt >= lim_foreign) begin
              active   = 1'b0;
              r.action = btrs_pkg::ACT_FAILED;
              r.err    = btrs_pkg::ERR_FOREIGN;
            end else begin
              foreign_cnt = foreign_cnt + 8'd1;
            end
          end else if (nack) begin
            active   = 1'b0;
            r.action = btrs_pkg::ACT_FAILED;
            r.err    = btrs_pkg::ERR_REMOTE_NACK;
            r.remote = ptotal;
          end else if (pblock == cur_block) begin
            r.action = btrs_pkg::ACT_ACK;
          end else if (pblock == cur_block + 32'd1) begin
            cur_block = pblock;
            if (pblock == 32'd1) remaining = longint'(ptotal);
            if (store == btrs_pkg::STORE_OK) begin
              remaining = remaining - longint'(plen);
              if (remaining <= 0) begin
                active   = 1'b0;
                r.action = btrs_pkg::ACT_FINISHED;
              end else begin
                r.action = btrs_pkg::ACT_ACK;
              end
            end else begin
              r.action = btrs_pkg::ACT_ACK;
              r.ack    = (store == btrs_pkg::STORE_WRITE_ERR) ? btrs_pkg::ACK_WRITE_ERR
                                                              : btrs_pkg::ACK_UNDEFINED;
            end
          end
        end
      end
    end
    r.sess = cur_session;
    r.blk  = cur_block;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin
    session_reply_t want;
    if (!rst_n) begin
      lim_timeouts = btrs_pkg::MaxTimeoutsReset;
      lim_bad      = btrs_pkg::MaxBadPktsReset;
      lim_foreign  = btrs_pkg::MaxForeignReset;
      cur_session  = '0;
      cur_block    = '0;
      remaining    = 0;
      timeout_cnt  = '0;
      bad_cnt      = '0;
      foreign_cnt  = '0;
      active       = 1'b0;
      reply_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          btrs_pkg::CFG_MAX_TIMEOUTS: lim_timeouts = cfg_data;
          btrs_pkg::CFG_MAX_BAD:      lim_bad = cfg_data;
          btrs_pkg::CFG_MAX_FOREIGN:  lim_foreign = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("result with no transfer waiting: action %0d", out_action);
          err_total++;
        end else begin
          want = reply_q.pop_front();
          n_checked++;
          check_field("action", want.action, out_action);
          check_field("ack_code", want.ack, out_ack_code);
          check_field("ack_session", want.sess, out_ack_session);
          check_field("ack_block", want.blk, out_ack_block);
          check_field("error_code", want.err, out_error_code);
          check_field("remote_error", want.remote, out_remote_error);
        end
      end
      if (in_valid && !in_stall) begin
        reply_q.push_back(session_step(btrs_pkg::mode_t'(in_mode), in_user_abort,
                                       in_store_result, in_is_data_command,
                                       in_packet_check_ok, in_packet_session,
                                       in_packet_is_nack, in_packet_block,
                                       in_packet_total_size, in_packet_data_length));
      end
    end
    pending    <= reply_q.size();
    mismatches <= err_total;
    checked    <= n_checked;
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the receiver session unit with directed session scenarios and then
// random well-formed transfers mixed with timeouts, bad, foreign and NACK
// packets over several limit settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int         CycleLimit    = 200000;
  localparam int         PhaseItems    = 180;
  localparam int         NumPhases     = 6;
  localparam int         HoldCycles    = 300;
  localparam logic [1:0] StoreOtherErr = 2'd2;
  localparam logic [1:0] StoreUnknown  = 2'd3;

  typedef struct {
    btrs_pkg::mode_t mode;
    logic            abort;
    logic [1:0]      store;
    logic            is_data;
    logic            chk;
    logic [15:0]     sess;
    logic            nack;
    logic [31:0]     blk;
    logic [31:0]     total;
    logic [10:0]     len;
  } xfer_item_t;

  logic        clk;
  logic        rst_n                 = 1'b0;
  logic        cfg_we                = 1'b0;
  logic [1:0]  cfg_index             = '0;
  logic [7:0]  cfg_data              = '0;
  logic        in_valid              = 1'b0;
  logic [1:0]  in_mode               = '0;
  logic        in_user_abort         = 1'b0;
  logic [1:0]  in_store_result       = '0;
  logic        in_is_data_command    = 1'b0;
  logic        in_packet_check_ok    = 1'b0;
  logic [15:0] in_packet_session     = '0;
  logic        in_packet_is_nack     = 1'b0;
  logic [31:0] in_packet_block       = '0;
  logic [31:0] in_packet_total_size  = '0;
  logic [10:0] in_packet_data_length = '0;
  logic        out_stall             = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [2:0]  out_action;
  logic [1:0]  out_ack_code;
  logic [15:0] out_ack_session;
  logic [31:0] out_ack_block;
  logic [2:0]  out_error_code;
  logic [31:0] out_remote_error;

  int pending;
  int mismatches;
  int checked;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_req    = 0;
  int          hold_ack    = 0;
  int          hold_left   = 0;
  int          cycle_count = 0;
  int          n_sent      = 0;
  logic [15:0] sess_track  = '0;
  logic [31:0] blk_track   = '0;
  longint      bytes_track = 0;

  block_transfer_receiver_session_unit i_dut (.*);
  btrs_session_checker i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic xfer_item_t pkt(input logic [31:0] blk, input logic [31:0] total,
                                     input logic [10:0] len);
    xfer_item_t it;
    it.mode    = btrs_pkg::MODE_PACKET;
    it.abort   = 1'b0;
    it.store   = btrs_pkg::STORE_OK;
    it.is_data = 1'b1;
    it.chk     = 1'b1;
    it.sess    = sess_track;
    it.nack    = 1'b0;
    it.blk     = blk;
    it.total   = total;
    it.len     = len;
    return it;
  endfunction

  function automatic xfer_item_t evt(input btrs_pkg::mode_t mode, input logic [1:0] store);
    xfer_item_t it;
    it       = pkt('0, '0, '0);
    it.mode  = mode;
    it.store = store;
    return it;
  endfunction

  function automatic xfer_item_t random_item();
    xfer_item_t  it;
    int          pick;
    logic [31:0] total;
    pick  = $urandom_range(99);
    total = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(4096));
    it    = pkt(blk_track + 32'd1, total,
                ($urandom_range(7) == 0) ? btrs_pkg::MaxBlockBytes[10:0]
                                         : 11'($urandom_range(1024)));
    if ($urandom_range(9) == 0) it.store = 2'($urandom_range(1, 3));
    if (pick < 8 || (pick < 60 && blk_track != 0 && bytes_track <= 0)) begin
      it.mode  = btrs_pkg::MODE_START;
      it.store = ($urandom_range(7) == 0) ? 2'($urandom_range(1, 3)) : btrs_pkg::STORE_OK;
    end else if (pick >= 94) begin
      it.mode    = btrs_pkg::mode_t'($urandom_range(3));
      it.abort   = 1'($urandom_range(1));
      it.store   = 2'($urandom_range(3));
      it.is_data = 1'($urandom_range(1));
      it.chk     = 1'($urandom_range(1));
      it.sess    = 16'($urandom);
      it.nack    = 1'($urandom_range(1));
      it.blk     = $urandom;
      it.total   = $urandom;
      it.len     = 11'($urandom_range(2047));
    end else if (pick >= 91) begin
      it.blk = $urandom;
    end else if (pick >= 89) begin
      it.is_data = 1'b0;
    end else if (pick >= 87) begin
      it.abort = 1'b1;
      it.mode  = btrs_pkg::mode_t'($urandom_range(1, 3));
    end else if (pick >= 85) begin
      it.nack  = 1'b1;
      it.total = $urandom;
    end else if (pick >= 80) begin
      it.sess = sess_track + 16'($urandom_range(1, 65535));
    end else if (pick >= 75) begin
      if ($urandom_range(1) == 1) it.chk = 1'b0;
      else it.len = 11'($urandom_range(1025, 2047));
    end else if (pick >= 72) begin
      it.mode = btrs_pkg::MODE_RECV_ERR;
    end else if (pick >= 66) begin
      it.mode = btrs_pkg::MODE_TIMEOUT;
    end else if (pick >= 60) begin
      it.blk = blk_track;
    end
    return it;
  endfunction

  task automatic send_item(input xfer_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_mode               <= it.mode;
    in_user_abort         <= it.abort;
    in_store_result       <= it.store;
    in_is_data_command    <= it.is_data;
    in_packet_check_ok    <= it.chk;
    in_packet_session     <= it.sess;
    in_packet_is_nack     <= it.nack;
    in_packet_block       <= it.blk;
    in_packet_total_size  <= it.total;
    in_packet_data_length <= it.len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    if (it.mode == btrs_pkg::MODE_START && it.store == btrs_pkg::STORE_OK) begin
      sess_track  = sess_track + 16'd1;
      blk_track   = '0;
      bytes_track = 0;
    end else if (it.mode == btrs_pkg::MODE_PACKET && !it.abort && it.is_data && it.chk &&
                 it.len <= btrs_pkg::MaxBlockBytes && it.sess == sess_track && !it.nack &&
                 it.blk == blk_track + 32'd1) begin
      blk_track = it.blk;
      if (it.blk == 32'd1) bytes_track = longint'(it.total);
      if (it.store == btrs_pkg::STORE_OK) bytes_track = bytes_track - longint'(it.len);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(input logic [7:0] t, input logic [7:0] b, input logic [7:0] f);
    cfg_we    <= 1'b1;
    cfg_index <= btrs_pkg::CFG_MAX_TIMEOUTS;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= btrs_pkg::CFG_MAX_BAD;
    cfg_data  <= b;
    @(posedge clk);
    cfg_index <= btrs_pkg::CFG_MAX_FOREIGN;
    cfg_data  <= f;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    xfer_item_t it;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 19;
    rx_idle_pct = 88;

    send_item(pkt(32'd1, 32'd100, 11'd10));
    send_item(evt(btrs_pkg::MODE_TIMEOUT, btrs_pkg::STORE_OK));
    send_item(evt(btrs_pkg::MODE_START, btrs_pkg::STORE_WRITE_ERR));
    send_item(evt(btrs_pkg::MODE_START, btrs_pkg::STORE_OK));
    send_item(pkt(32'd1, 32'd2000, 11'd1024));
    send_item(pkt(32'd1, 32'd2000, 11'd1024));
    send_item(pkt(32'd3, 32'd0, 11'd5));
    it = pkt(32'd2, 32'd0, 11'd1024);
    it.store = btrs_pkg::STORE_WRITE_ERR;
    send_item(it);
    it = pkt(32'd3, 32'd0, 11'd7);
    it.store = StoreOtherErr;
    send_item(it);
    it = pkt(32'd4, 32'd0, 11'd7);
    it.store = StoreUnknown;
    send_item(it);
    send_item(pkt(32'd5, 32'd0, 11'd1025));
    it = pkt(32'd5, 32'd0, 11'd8);
    it.chk = 1'b0;
    send_item(it);
    it = pkt(32'd5, 32'd0, 11'd8);
    it.is_data = 1'b0;
    send_item(it);
    it = pkt(32'd5, 32'd0, 11'd8);
    it.sess = ~sess_track;
    send_item(it);
    send_item(evt(btrs_pkg::MODE_TIMEOUT, btrs_pkg::STORE_OK));
    send_item(evt(btrs_pkg::MODE_RECV_ERR, btrs_pkg::STORE_OK));
    send_item(pkt(32'd5, 32'd0, 11'd1024));
    send_item(evt(btrs_pkg::MODE_START, btrs_pkg::STORE_OK));
    send_item(evt(btrs_pkg::MODE_START, btrs_pkg::STORE_OK));
    send_item(pkt(32'd1, 32'd0, 11'd0));
    send_item(evt(btrs_pkg::MODE_START, btrs_pkg::STORE_OK));
    it = pkt(32'd1, 32'hFFFF_FFFF, 11'd0);
    it.nack = 1'b1;
    send_item(it);
    send_item(evt(btrs_pkg::MODE_START, btrs_pkg::STORE_OK));
    it = evt(btrs_pkg::MODE_TIMEOUT, btrs_pkg::STORE_OK);
    it.abort = 1'b1;
    send_item(it);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0:       write_limits(8'd0, 8'd0, 8'd0);
        1:       write_limits(8'd255, 8'd255, 8'd255);
        2:       write_limits(8'd1, 8'd2, 8'd1);
        3:       write_limits(8'($urandom), 8'($urandom), 8'($urandom));
        4:       write_limits(8'd3, 8'd0, 8'd255);
        default: write_limits(8'($urandom_range(6)), 8'($urandom_range(6)),
                              8'($urandom_range(6)));
      endcase
      tx_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 88 : 0;
      rx_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 19 : 0;
      if (ph == 4) hold_req <= hold_req + 1;
      repeat (PhaseItems) send_item(random_item());
    end
    drain();

    $display("Run covered %0d transfers under %0d limit settings, %0d results compared",
             n_sent, NumPhases + 1, checked);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
src/btrs_pkg.sv
src/block_transfer_receiver_session_unit.sv
sim/btrs_session_checker.sv
sim/tb.sv
